FILE: sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and character classifier
// Item formats for the middle queue and the result queue, plus the
// standard base64 alphabet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// classified character as held in the middle queue
	typedef struct packed {
		logic [5:0] sextet;
		logic       invalid;
		logic       pad;
		logic       fin;
	} cls_t;

	// one result item
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       done;
		logic       bad;
	} res_t;

	// alphabet lookup, invalid characters give sextet 0
	function automatic cls_t classify(input logic [7:0] c, input logic fin);
		cls_t       r;
		logic [7:0] d;
		d = 8'd0;
		r.invalid = 1'b0;
		if (c inside {[8'h41:8'h5A]}) begin
			d = c - 8'h41;
		end else if (c inside {[8'h61:8'h7A]}) begin
			d = c - 8'h61 + 8'd26;
		end else if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30 + 8'd52;
		end else if (c == 8'h2B) begin
			d = 8'd62;
		end else if (c == 8'h2F) begin
			d = 8'd63;
		end else begin
			r.invalid = 1'b1;
		end
		r.sextet = d[5:0];
		r.pad    = (c == PAD_CHAR);
		r.fin    = fin;
		return r;
	endfunction

endpackage

FILE: sv/base64_decoder_strict.sv
// ----------------------------------------------------------------------------
// base64_decoder_strict: streaming strict base64 decoder
// Decodes one character per item into bytes, with pad and length checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive char_code and is_final and
//   raise push; the item is taken on a clock edge where full is low.
//   Mark the last character of each message with is_final.
//   Output side is a queue read port: while empty is low the oldest result
//   is on data_byte, byte_valid, message_done and bad_input; pop takes it.
//   Every character gives exactly one result. byte_valid marks a decoded
//   byte; bad_input is sticky within a message and is final on the result
//   with message_done set. After that result the decoder starts fresh.
//   An accepted character is stored in a two-entry queue after the
//   classifier, and its result in a two-entry result queue after the quad
//   decoder that drives the result ports; one item per cycle is sustained
//   while the receiver pops without stalling.
//   When the receiver stalls, the result queue fills, then the middle
//   queue, then full rises; no item is dropped. Reset empties both queues
//   and clears the quad position and error flag.
// ----------------------------------------------------------------------------
module base64_decoder_strict (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_code,
	input  logic       is_final,
	input  logic       push,
	output logic       full,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       message_done,
	output logic       bad_input,
	output logic       empty,
	input  logic       pop
);
	import b64d_pkg::*;

	logic q_valid;
	logic q_pop;
	cls_t q_item;

	// classifier and middle queue
	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.is_final  (is_final),
		.push      (push),
		.full      (full),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	// quad decoder and result queue
	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.message_done (message_done),
		.bad_input    (bad_input),
		.empty        (empty),
		.pop          (pop)
	);

endmodule

FILE: sv/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: input classifier and middle queue
// Looks up each incoming character and stores the classified item in a
// two-entry queue that the back end drains at its own pace.
// ----------------------------------------------------------------------------
module b64d_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       char_code,
	input  logic             is_final,
	input  logic             push,
	output logic             full,
	output logic             q_valid,
	output b64d_pkg::cls_t   q_item,
	input  logic             q_pop
);
	import b64d_pkg::*;

	cls_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       wr;
	logic       rd;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_item  = mem_q[rd_ptr_q];
	assign wr      = push && !full;
	assign rd      = q_pop && q_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= classify(char_code, is_final);
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr) wr_ptr_q <= !wr_ptr_q;
			if (rd) rd_ptr_q <= !rd_ptr_q;
			case ({wr, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("front queue count out of range");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		full && !q_pop |=> full) else $error("front queue lost an item");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd |=> count_q == $past(count_q) + 2'd1)
		else $error("front queue count did not advance");

endmodule

FILE: sv/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: quad decoder and result queue
// Tracks the position within a quad, merges sextets into bytes, checks
// padding and length, and holds results in a two-entry output queue.
// ----------------------------------------------------------------------------
module b64d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  b64d_pkg::cls_t   q_item,
	output logic             q_pop,
	output logic [7:0]       data_byte,
	output logic             byte_valid,
	output logic             message_done,
	output logic             bad_input,
	output logic             empty,
	input  logic             pop
);
	import b64d_pkg::*;

	localparam logic [1:0] PH0 = 2'd0;
	localparam logic [1:0] PH1 = 2'd1;
	localparam logic [1:0] PH2 = 2'd2;
	localparam logic [1:0] PH3 = 2'd3;

	logic [1:0] phase_q;
	logic [5:0] held_q;
	logic       expect_q;
	logic       err_q;

	res_t       out_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic       take;
	logic       rd;
	logic       bad;
	logic       emit;
	logic       err_nx;
	logic       hold_ld;
	logic       expect_nx;
	logic [7:0] byte_v;
	res_t       res;

	assign take  = q_valid && (count_q != 2'd2);
	assign q_pop = take;
	assign empty = (count_q == 2'd0);
	assign rd    = pop && !empty;

	// per-character decode
	always_comb begin
		bad       = 1'b0;
		emit      = 1'b0;
		hold_ld   = 1'b0;
		byte_v    = 8'd0;
		expect_nx = expect_q;
		case (phase_q)
			PH0: begin
				bad     = q_item.invalid;
				hold_ld = 1'b1;
			end
			PH1: begin
				bad     = q_item.invalid;
				byte_v  = {held_q, q_item.sextet[5:4]};
				emit    = 1'b1;
				hold_ld = 1'b1;
			end
			PH2: begin
				if (q_item.pad) begin
					expect_nx = 1'b1;
				end else begin
					bad     = q_item.invalid;
					byte_v  = {held_q[3:0], q_item.sextet[5:2]};
					emit    = 1'b1;
					hold_ld = 1'b1;
				end
			end
			PH3: begin
				if (expect_q) begin
					bad = !q_item.pad || !q_item.fin;
				end else if (q_item.pad) begin
					bad = !q_item.fin;
				end else begin
					bad    = q_item.invalid;
					byte_v = {held_q[1:0], q_item.sextet};
					emit   = 1'b1;
				end
				expect_nx = 1'b0;
			end
			default: begin
				bad = 1'b1;
			end
		endcase
		if (q_item.fin && phase_q != PH3) bad = 1'b1;
		err_nx    = err_q || bad;
		res.valid = emit && !err_nx;
		res.data  = res.valid ? byte_v : 8'd0;
		res.done  = q_item.fin;
		res.bad   = err_nx;
	end

	// quad state, cleared after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH0;
			held_q   <= 6'd0;
			expect_q <= 1'b0;
			err_q    <= 1'b0;
		end else if (take) begin
			if (q_item.fin) begin
				phase_q  <= PH0;
				held_q   <= 6'd0;
				expect_q <= 1'b0;
				err_q    <= 1'b0;
			end else begin
				phase_q  <= phase_q + 2'd1;
				expect_q <= expect_nx;
				err_q    <= err_nx;
				if (hold_ld) held_q <= q_item.sextet;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (take) begin
			out_q[wr_ptr_q] <= res;
		end
	end

	// result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (take) wr_ptr_q <= !wr_ptr_q;
			if (rd)   rd_ptr_q <= !rd_ptr_q;
			case ({take, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign data_byte    = out_q[rd_ptr_q].data;
	assign byte_valid   = out_q[rd_ptr_q].valid;
	assign message_done = out_q[rd_ptr_q].done;
	assign bad_input    = out_q[rd_ptr_q].bad;

	a_valid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !(res.valid && res.bad)) else $error("byte emitted after error");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		take && !res.valid |-> res.data == 8'd0) else $error("stray data bits");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && q_item.fin |=> phase_q == PH0 && !err_q && !expect_q)
		else $error("state not cleared after final item");

	a_pad_phase: assert property (@(posedge clk) disable iff (!arst_n)
		expect_q |-> phase_q == PH3) else $error("pending pad outside last position");

endmodule
